// ===== src/elrp_pkg.sv =====
// Package for the event log record parser.
// Holds the stage-to-stage word type and the record and lead-byte codes.
// No dependencies.
package elrp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned FieldW = 5;
  localparam int unsigned ValueW = 64;

  localparam logic [ByteW-1:0] TYPE_QUERY   = 8'd0;
  localparam logic [ByteW-1:0] TYPE_EXECUTE = 8'd16;
  localparam logic [ByteW-1:0] TYPE_PREPARE = 8'd17;

  localparam logic [ByteW-1:0] LEAD_MAX_DIRECT = 8'hfb;
  localparam logic [ByteW-1:0] LEAD_TWO        = 8'hfc;
  localparam logic [ByteW-1:0] LEAD_THREE      = 8'hfd;
  localparam logic [ByteW-1:0] LEAD_NULL       = 8'hff;

  localparam logic [FieldW-1:0] FID_TYPE = 5'd0;

  typedef struct packed {
    logic             vld;
    logic [ByteW-1:0] data;
  } elrp_word_t;

endpackage

// ===== src/elrp_in_stage.sv =====
// Input register of the event log record parser.
// Captures one stream word and holds it until the parse stage takes it.
// Depends on elrp_pkg.
module elrp_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [elrp_pkg::ByteW-1:0]      in_data_byte,
  output logic                            in_stall,
  input  logic                            take,
  output elrp_pkg::elrp_word_t            word_o
);
  import elrp_pkg::*;

  logic             vld_r;
  logic [ByteW-1:0] data_r;
  logic             load;

  assign load     = !vld_r || take;
  assign in_stall = !load;
  assign word_o   = '{vld: vld_r, data: data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= in_valid;
    end
    if (load && in_valid) begin
      data_r <= in_data_byte;
    end
  end

endmodule

// ===== src/elrp_parse.sv =====
// Parse stage of the event log record parser.
// Holds the record phase, integer decode state and the result register.
// Depends on elrp_pkg.
module elrp_parse (
  input  logic                            clk,
  input  logic                            rst_n,
  input  elrp_pkg::elrp_word_t            word_i,
  output logic                            take,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [elrp_pkg::FieldW-1:0]     out_field_id,
  output logic [elrp_pkg::ValueW-1:0]     out_field_value,
  output logic                            out_is_string_byte,
  output logic                            out_last_of_record
);
  import elrp_pkg::*;

  typedef enum logic [4:0] {
    PH_HEADER     = 5'd0,
    PH_THREAD     = 5'd1,
    PH_USER_LEN   = 5'd2,
    PH_USER       = 5'd3,
    PH_SCHEMA_LEN = 5'd4,
    PH_SCHEMA     = 5'd5,
    PH_CLIENT_LEN = 5'd6,
    PH_CLIENT     = 5'd7,
    PH_HOST       = 5'd8,
    PH_SERVER_LEN = 5'd9,
    PH_SERVER     = 5'd10,
    PH_START      = 5'd11,
    PH_END        = 5'd12,
    PH_STMT       = 5'd13,
    PH_ROWS_AFF   = 5'd14,
    PH_ROWS_SENT  = 5'd15,
    PH_DIGEST     = 5'd16,
    PH_QUERY_LEN  = 5'd17,
    PH_QUERY      = 5'd18,
    PH_TYPE       = 5'd19
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [2:0]          hdr_cnt_r, hdr_cnt_nxt;
  logic [3:0]          left_r, left_nxt;
  logic [2:0]          idx_r, idx_nxt;
  logic [ValueW-1:0]   acc_r, acc_nxt;
  logic [ValueW-1:0]   str_left_r, str_left_nxt;
  logic [ByteW-1:0]    rec_type_r, rec_type_nxt;

  logic                out_vld_r;
  logic [FieldW-1:0]   fid_r, fid_nxt;
  logic [ValueW-1:0]   val_r, val_nxt;
  logic                str_r, str_nxt;
  logic                last_r, last_nxt;
  logic                emit;

  logic [ByteW-1:0]    b;
  logic [ValueW-1:0]   acc_ins;
  logic                int_done;
  logic [ValueW-1:0]   int_val;
  logic                known_type;
  logic                has_stmt;

  assign b          = word_i.data;
  assign take       = word_i.vld && (!out_vld_r || !out_stall);
  assign acc_ins    = acc_r | (ValueW'(b) << {idx_r, 3'b000});
  assign known_type = (b == TYPE_QUERY) || (b == TYPE_EXECUTE) || (b == TYPE_PREPARE);
  assign has_stmt   = (rec_type_r == TYPE_EXECUTE) || (rec_type_r == TYPE_PREPARE);

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    left_nxt     = left_r;
    idx_nxt      = idx_r;
    acc_nxt      = acc_r;
    str_left_nxt = str_left_r;
    rec_type_nxt = rec_type_r;
    emit         = 1'b0;
    fid_nxt      = 5'(phase_r);
    val_nxt      = ValueW'(b);
    str_nxt      = 1'b0;
    last_nxt     = 1'b0;
    int_done     = 1'b0;
    int_val      = '0;

    case (phase_r)
      PH_HEADER: begin
        if (hdr_cnt_r == 3'd7) begin
          hdr_cnt_nxt = 3'd0;
          phase_nxt   = PH_TYPE;
        end else begin
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
        end
      end
      PH_TYPE: begin
        rec_type_nxt = b;
        emit         = 1'b1;
        fid_nxt      = FID_TYPE;
        if (known_type) begin
          phase_nxt = PH_THREAD;
        end else begin
          phase_nxt = PH_HEADER;
          last_nxt  = 1'b1;
        end
      end
      PH_USER, PH_SCHEMA, PH_CLIENT, PH_SERVER, PH_QUERY: begin
        emit    = 1'b1;
        str_nxt = 1'b1;
        if (str_left_r != '0) begin
          str_left_nxt = str_left_r - ValueW'(1);
        end
        if (str_left_r <= ValueW'(1)) begin
          if (phase_r == PH_QUERY) begin
            phase_nxt = PH_HEADER;
            last_nxt  = 1'b1;
          end else begin
            phase_nxt = phase_t'(5'(phase_r) + 5'd1);
          end
        end
      end
      PH_THREAD, PH_USER_LEN, PH_SCHEMA_LEN, PH_CLIENT_LEN, PH_HOST, PH_SERVER_LEN,
      PH_START, PH_END, PH_STMT, PH_ROWS_AFF, PH_ROWS_SENT, PH_DIGEST,
      PH_QUERY_LEN: begin
        if (left_r == 4'd0) begin
          if (b <= LEAD_MAX_DIRECT) begin
            int_done = 1'b1;
            int_val  = ValueW'(b);
          end else if (b == LEAD_NULL) begin
            int_done = 1'b1;
          end else begin
            left_nxt = (b == LEAD_TWO) ? 4'd2 : (b == LEAD_THREE) ? 4'd3 : 4'd8;
            idx_nxt  = 3'd0;
            acc_nxt  = '0;
          end
        end else begin
          acc_nxt  = acc_ins;
          idx_nxt  = idx_r + 3'd1;
          left_nxt = left_r - 4'd1;
          if (left_r == 4'd1) begin
            int_done = 1'b1;
            int_val  = acc_ins;
          end
        end
        if (int_done) begin
          emit    = 1'b1;
          val_nxt = int_val;
          case (phase_r)
            PH_USER_LEN, PH_SCHEMA_LEN, PH_CLIENT_LEN, PH_SERVER_LEN, PH_QUERY_LEN: begin
              str_left_nxt = int_val;
              if (int_val != '0) begin
                phase_nxt = phase_t'(5'(phase_r) + 5'd1);
              end else if (phase_r == PH_QUERY_LEN) begin
                phase_nxt = PH_HEADER;
                last_nxt  = 1'b1;
              end else begin
                phase_nxt = phase_t'(5'(phase_r) + 5'd2);
              end
            end
            PH_HOST: begin
              phase_nxt = (int_val == '1) ? PH_START : PH_SERVER_LEN;
            end
            PH_END: begin
              phase_nxt = has_stmt ? PH_STMT : PH_ROWS_AFF;
            end
            default: begin
              phase_nxt = phase_t'(5'(phase_r) + 5'd1);
            end
          endcase
        end
      end
      default: begin
        phase_nxt   = PH_HEADER;
        hdr_cnt_nxt = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_cnt_r  <= 3'd0;
      left_r     <= 4'd0;
      idx_r      <= 3'd0;
      acc_r      <= '0;
      str_left_r <= '0;
      rec_type_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (take) begin
        phase_r    <= phase_nxt;
        hdr_cnt_r  <= hdr_cnt_nxt;
        left_r     <= left_nxt;
        idx_r      <= idx_nxt;
        acc_r      <= acc_nxt;
        str_left_r <= str_left_nxt;
        rec_type_r <= rec_type_nxt;
        out_vld_r  <= emit;
      end
    end
    if (take && emit) begin
      fid_r  <= fid_nxt;
      val_r  <= val_nxt;
      str_r  <= str_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_field_id       = fid_r;
  assign out_field_value    = val_r;
  assign out_is_string_byte = str_r;
  assign out_last_of_record = last_r;

  a_hdr_cnt_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r != 3'd0 |-> phase_r == PH_HEADER)
    else $error("header count set outside header phase");

  a_lenenc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= 4'd8)
    else $error("length-encoded byte count out of range");

  a_lenenc_not_string: assert property (@(posedge clk) disable iff (!rst_n)
    left_r != 4'd0 |-> !(phase_r == PH_HEADER || phase_r == PH_TYPE || phase_r == PH_USER ||
                         phase_r == PH_SCHEMA || phase_r == PH_CLIENT ||
                         phase_r == PH_SERVER || phase_r == PH_QUERY))
    else $error("integer decode pending in a non-integer phase");

  a_last_string_is_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && last_r && str_r |-> fid_r == 5'(PH_QUERY))
    else $error("record ended on a string byte other than query text");

  a_take_frees_output: assert property (@(posedge clk) disable iff (!rst_n)
    take && !emit |=> !out_vld_r)
    else $error("stale result after a word with no result");

endmodule

// ===== src/event_log_record_parser.sv =====
// Top level of the event log record parser.
// Instantiates the input register (elrp_in_stage) and parse stage (elrp_parse).
// Depends on elrp_pkg.
//
//  channel | ports                                     | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, in_data_byte          | stream in
//  out     | out_valid, out_stall, out_field_id,       | fields out
//          | out_field_value, out_is_string_byte,      |
//          | out_last_of_record                        |
//
// One byte per cycle sustained while out_stall is low; a result is valid in the cycle after its byte is taken.
// The byte path is input register, one pass of phase decode, result register.
// Reset (rst_n low, synchronous) returns to the header of a new record.
// out_stall holds a valid result register; the input register still takes a byte while it is empty.
module event_log_record_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [elrp_pkg::ByteW-1:0]      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [elrp_pkg::FieldW-1:0]     out_field_id,
  output logic [elrp_pkg::ValueW-1:0]     out_field_value,
  output logic                            out_is_string_byte,
  output logic                            out_last_of_record
);
  import elrp_pkg::*;

  elrp_word_t word;
  logic       take;

  elrp_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .take         (take),
    .word_o       (word)
  );

  elrp_parse u_parse (
    .clk                (clk),
    .rst_n              (rst_n),
    .word_i             (word),
    .take               (take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_field_id       (out_field_id),
    .out_field_value    (out_field_value),
    .out_is_string_byte (out_is_string_byte),
    .out_last_of_record (out_last_of_record)
  );

endmodule

// ===== tb/elrp_tb_pkg.sv =====
// Field codes and the record field tracker for the event log record parser bench.
// The tracker follows the byte stream, queues the fields it implies and matches results.
// Depends on elrp_pkg.
package elrp_tb_pkg;

  import elrp_pkg::*;

  localparam logic [FieldW-1:0] FID_THREAD       = 5'd1;
  localparam logic [FieldW-1:0] FID_USER_LEN     = 5'd2;
  localparam logic [FieldW-1:0] FID_USER_BYTES   = 5'd3;
  localparam logic [FieldW-1:0] FID_SCHEMA_LEN   = 5'd4;
  localparam logic [FieldW-1:0] FID_SCHEMA_BYTES = 5'd5;
  localparam logic [FieldW-1:0] FID_CLIENT_LEN   = 5'd6;
  localparam logic [FieldW-1:0] FID_CLIENT_BYTES = 5'd7;
  localparam logic [FieldW-1:0] FID_HOST         = 5'd8;
  localparam logic [FieldW-1:0] FID_SERVER_LEN   = 5'd9;
  localparam logic [FieldW-1:0] FID_SERVER_BYTES = 5'd10;
  localparam logic [FieldW-1:0] FID_START        = 5'd11;
  localparam logic [FieldW-1:0] FID_END          = 5'd12;
  localparam logic [FieldW-1:0] FID_STMT         = 5'd13;
  localparam logic [FieldW-1:0] FID_AFFECTED     = 5'd14;
  localparam logic [FieldW-1:0] FID_ROWS_SENT    = 5'd15;
  localparam logic [FieldW-1:0] FID_DIGEST       = 5'd16;
  localparam logic [FieldW-1:0] FID_QUERY_LEN    = 5'd17;
  localparam logic [FieldW-1:0] FID_QUERY_BYTES  = 5'd18;

  localparam logic [FieldW-1:0] PH_HEADER = 5'd0;
  localparam logic [FieldW-1:0] PH_TYPE   = 5'd19;

  localparam logic [ByteW-1:0] LEAD_EIGHT = 8'hfe;

  typedef struct packed {
    logic [FieldW-1:0] id;
    logic [ValueW-1:0] value;
    logic              str_byte;
    logic              rec_end;
  } parsed_field_t;

  function automatic bit is_record_type(logic [ByteW-1:0] b);
    return b == TYPE_QUERY || b == TYPE_EXECUTE || b == TYPE_PREPARE;
  endfunction

  function automatic bit is_text_field(logic [FieldW-1:0] p);
    return p == FID_USER_BYTES || p == FID_SCHEMA_BYTES || p == FID_CLIENT_BYTES ||
           p == FID_SERVER_BYTES || p == FID_QUERY_BYTES;
  endfunction

  class record_field_tracker;
    parsed_field_t     fields_due[$];
    int unsigned       errors;
    logic [FieldW-1:0] phase;
    logic [2:0]        hdr_count;
    logic [3:0]        lead_left;
    logic [2:0]        lead_idx;
    logic [ValueW-1:0] accum;
    logic [ValueW-1:0] text_left;
    logic [ByteW-1:0]  rec_type;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase     = PH_HEADER;
      hdr_count = '0;
      lead_left = '0;
      lead_idx  = '0;
      accum     = '0;
      text_left = '0;
      rec_type  = '0;
      fields_due.delete();
    endfunction

    function void due(logic [FieldW-1:0] id, logic [ValueW-1:0] value, logic str_byte,
                      logic rec_end);
      parsed_field_t f;
      f.id       = id;
      f.value    = value;
      f.str_byte = str_byte;
      f.rec_end  = rec_end;
      fields_due.push_back(f);
    endfunction

    function void take_byte(logic [ByteW-1:0] b);
      logic [FieldW-1:0] p;
      logic [ValueW-1:0] v;
      p = phase;
      if (p == PH_HEADER) begin
        if (hdr_count == 3'd7) begin
          hdr_count = '0;
          phase = PH_TYPE;
        end else begin
          hdr_count = hdr_count + 3'd1;
        end
        return;
      end
      if (p == PH_TYPE) begin
        rec_type = b;
        if (is_record_type(b)) begin
          phase = FID_THREAD;
          due(FID_TYPE, 64'(b), 1'b0, 1'b0);
        end else begin
          phase = PH_HEADER;
          due(FID_TYPE, 64'(b), 1'b0, 1'b1);
        end
        return;
      end
      if (p > FID_QUERY_BYTES) begin
        phase = PH_HEADER;
        hdr_count = '0;
        return;
      end
      if (is_text_field(p)) begin
        if (text_left != 0) text_left = text_left - 64'd1;
        if (text_left == 0) begin
          if (p == FID_QUERY_BYTES) begin
            phase = PH_HEADER;
            due(p, 64'(b), 1'b1, 1'b1);
            return;
          end
          phase = p + 5'd1;
        end
        due(p, 64'(b), 1'b1, 1'b0);
        return;
      end
      if (lead_left == 0) begin
        if (b <= LEAD_MAX_DIRECT) begin
          v = 64'(b);
        end else if (b == LEAD_NULL) begin
          v = '0;
        end else begin
          lead_left = (b == LEAD_TWO) ? 4'd2 : (b == LEAD_THREE) ? 4'd3 : 4'd8;
          lead_idx  = '0;
          accum     = '0;
          return;
        end
      end else begin
        accum = accum | (64'(b) << (8 * lead_idx));
        lead_idx  = lead_idx + 3'd1;
        lead_left = lead_left - 4'd1;
        if (lead_left != 0) return;
        v = accum;
      end
      if (p == FID_USER_LEN || p == FID_SCHEMA_LEN || p == FID_CLIENT_LEN ||
          p == FID_SERVER_LEN || p == FID_QUERY_LEN) begin
        text_left = v;
        if (v != 0) begin
          phase = p + 5'd1;
        end else if (p == FID_QUERY_LEN) begin
          phase = PH_HEADER;
          due(p, v, 1'b0, 1'b1);
          return;
        end else begin
          phase = p + 5'd2;
        end
      end else if (p == FID_HOST) begin
        phase = (v == '1) ? FID_START : FID_SERVER_LEN;
      end else if (p == FID_END) begin
        phase = (rec_type == TYPE_EXECUTE || rec_type == TYPE_PREPARE) ? FID_STMT : FID_AFFECTED;
      end else begin
        phase = p + 5'd1;
      end
      due(p, v, 1'b0, 1'b0);
    endfunction

    task flag_mismatch(string what);
      $display("%0t: mismatch, %s", $time, what);
      errors++;
    endtask

    task match_field(parsed_field_t got);
      parsed_field_t want;
      if (fields_due.size() == 0) begin
        flag_mismatch($sformatf("field %0d value %h with nothing due", got.id, got.value));
        return;
      end
      want = fields_due.pop_front();
      if (got.id != want.id)
        flag_mismatch($sformatf("field id %0d, want %0d", got.id, want.id));
      if (got.value != want.value)
        flag_mismatch($sformatf("field %0d value %h, want %h", want.id, got.value, want.value));
      if (got.str_byte != want.str_byte)
        flag_mismatch($sformatf("field %0d string flag %b, want %b", want.id, got.str_byte,
                                want.str_byte));
      if (got.rec_end != want.rec_end)
        flag_mismatch($sformatf("field %0d record end %b, want %b", want.id, got.rec_end,
                                want.rec_end));
    endtask
  endclass

endpackage

// ===== tb/tb_top.sv =====
// Bench top for event_log_record_parser: builds records, broken records and noise,
// drives the byte channel with gaps and stalls, and matches every field it emits.
// Depends on elrp_pkg and elrp_tb_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import elrp_pkg::*;
  import elrp_tb_pkg::*;

  localparam int unsigned ByteTarget = 1700;
  localparam int unsigned QuietFrom  = 1450;
  localparam int unsigned StallLimit = 1000;

  typedef enum int {EncAny, EncDirect, EncNull, EncTwo, EncThree, EncEight} lenenc_form_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [ByteW-1:0]  in_data_byte = '0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [FieldW-1:0] out_field_id;
  logic [ValueW-1:0] out_field_value;
  logic              out_is_string_byte;
  logic              out_last_of_record;

  record_field_tracker tracker = new();
  logic [ByteW-1:0]    stream_q[$];
  int unsigned         n_taken     = 0;
  int unsigned         idle_cycles = 0;
  bit                  in_gaps     = 1'b0;
  bit                  out_gaps    = 1'b0;

  event_log_record_parser i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_field_id       (out_field_id),
    .out_field_value    (out_field_value),
    .out_is_string_byte (out_is_string_byte),
    .out_last_of_record (out_last_of_record)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [ValueW-1:0] pick_value(lenenc_form_t f);
    case (f)
      EncDirect: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return 64'(LEAD_MAX_DIRECT);
          default: return 64'($urandom_range(0, 251));
        endcase
      end
      EncNull: return '0;
      EncTwo: return $urandom_range(0, 1) ? 64'hffff : 64'($urandom_range(0, 16'hffff));
      EncThree: return $urandom_range(0, 1) ? 64'hff_ffff : 64'($urandom_range(0, 24'hff_ffff));
      EncEight: begin
        case ($urandom_range(0, 3))
          0: return '1;
          1: return 64'hffff_ffff_ffff_fffe;
          default: return {$urandom(), $urandom()};
        endcase
      end
      default: return pick_value(lenenc_form_t'($urandom_range(EncDirect, EncEight)));
    endcase
  endfunction

  function automatic void put_int(logic [ValueW-1:0] v, lenenc_form_t f);
    lenenc_form_t g;
    int           n;
    g = f;
    n = 0;
    if (g == EncAny) begin
      g = lenenc_form_t'($urandom_range(EncDirect, EncEight));
      if (g == EncNull && v != 0) g = EncDirect;
    end
    if (g == EncNull && v != 0) g = EncEight;
    if (g == EncDirect && v > 64'(LEAD_MAX_DIRECT)) g = EncTwo;
    if (g == EncTwo && v > 64'hffff) g = EncThree;
    if (g == EncThree && v > 64'hff_ffff) g = EncEight;
    case (g)
      EncDirect: stream_q.push_back(v[7:0]);
      EncNull: stream_q.push_back(LEAD_NULL);
      EncTwo: begin
        stream_q.push_back(LEAD_TWO);
        n = 2;
      end
      EncThree: begin
        stream_q.push_back(LEAD_THREE);
        n = 3;
      end
      default: begin
        stream_q.push_back(LEAD_EIGHT);
        n = 8;
      end
    endcase
    for (int i = 0; i < n; i++) stream_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_text(lenenc_form_t f, int len);
    put_int(64'(len), f);
    repeat (len) stream_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic int pick_len(int fixed);
    if (fixed >= 0) return fixed;
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 300);
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [ByteW-1:0] known_kind();
    case ($urandom_range(0, 2))
      0: return TYPE_QUERY;
      1: return TYPE_EXECUTE;
      default: return TYPE_PREPARE;
    endcase
  endfunction

  function automatic logic [ByteW-1:0] unknown_kind();
    logic [ByteW-1:0] t;
    do t = 8'($urandom_range(0, 255)); while (is_record_type(t));
    return t;
  endfunction

  function automatic void build_record(logic [ByteW-1:0] rec_kind, lenenc_form_t f, int len,
                                       bit host_ones, bit endless);
    logic [ValueW-1:0] host;
    repeat (8) stream_q.push_back(8'($urandom_range(0, 255)));
    stream_q.push_back(rec_kind);
    if (!is_record_type(rec_kind)) return;
    put_int(pick_value(f), f);
    repeat (3) put_text(f, pick_len(len));
    host = host_ones ? '1 : pick_value(f);
    put_int(host, f);
    if (host != '1) put_text(f, pick_len(len));
    repeat (2) put_int(pick_value(f), f);
    if (rec_kind != TYPE_QUERY) put_int(pick_value(f), f);
    repeat (3) put_int(pick_value(f), f);
    if (endless) begin
      put_int('1, EncEight);
      repeat (40) stream_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      put_text(f, pick_len(len));
    end
  endfunction

  task automatic send_byte(logic [ByteW-1:0] b);
    if (in_gaps && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(b);
    n_taken++;
  endtask

  task automatic send_stream(int n);
    for (int i = 0; i < n; i++) send_byte(stream_q[i]);
    stream_q.delete();
  endtask

  task automatic send_record(logic [ByteW-1:0] rec_kind, lenenc_form_t f, int len,
                             bit host_ones, bit endless);
    build_record(rec_kind, f, len, host_ones, endless);
    send_stream(stream_q.size());
  endtask

  // steer the parser back to the start of a record header
  task automatic realign();
    logic [ByteW-1:0] b;
    while (tracker.phase != PH_HEADER || tracker.hdr_count != 0) begin
      if (tracker.phase == PH_HEADER || is_text_field(tracker.phase))
        b = 8'($urandom_range(0, 255));
      else if (tracker.phase == PH_TYPE)
        b = unknown_kind();
      else
        b = 8'h00;
      send_byte(b);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.fields_due.size() != 0);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (out_gaps && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        tracker.match_field({out_field_id, out_field_value, out_is_string_byte,
                             out_last_of_record});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int          pick;
    int unsigned records;
    records = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    tracker.clear();
    in_gaps  = 1'b1;
    out_gaps = 1'b1;

    send_record(8'hff, EncAny, -1, 1'b0, 1'b0);
    send_record(8'h01, EncAny, -1, 1'b0, 1'b0);
    send_record(TYPE_QUERY, EncDirect, 0, 1'b0, 1'b0);
    send_record(TYPE_QUERY, EncNull, 0, 1'b0, 1'b0);
    send_record(TYPE_EXECUTE, EncTwo, 1, 1'b1, 1'b0);
    send_record(TYPE_PREPARE, EncThree, 2, 1'b0, 1'b0);
    send_record(TYPE_EXECUTE, EncEight, 3, 1'b0, 1'b0);
    send_record(TYPE_PREPARE, EncAny, -1, 1'b1, 1'b0);
    send_record(8'h12, EncAny, -1, 1'b0, 1'b0);
    send_record(8'h0f, EncAny, -1, 1'b0, 1'b0);

    while (n_taken < ByteTarget) begin
      in_gaps  = n_taken < QuietFrom && $urandom_range(0, 3) != 0;
      out_gaps = n_taken < QuietFrom && $urandom_range(0, 3) != 0;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        send_record(known_kind(), EncAny, -1, $urandom_range(0, 3) == 0, 1'b0);
      end else if (pick < 16) begin
        send_record(unknown_kind(), EncAny, -1, 1'b0, 1'b0);
      end else if (pick < 18) begin
        build_record(known_kind(), EncAny, -1, $urandom_range(0, 3) == 0, 1'b0);
        send_stream($urandom_range(1, stream_q.size() - 1));
        realign();
      end else begin
        repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 251)));
        realign();
      end
      records++;
      if (records % 12 == 0) drain();
    end

    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    send_record(TYPE_QUERY, EncAny, -1, 1'b0, 1'b1);
    in_valid <= 1'b0;
    while (tracker.fields_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.fields_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/elrp_pkg.sv
src/elrp_in_stage.sv
src/elrp_parse.sv
src/event_log_record_parser.sv
tb/elrp_tb_pkg.sv
tb/tb_top.sv
